// ----- sv/wall_follow_speed_select_defines.svh -----
// Assertion macros shared by the wall follow speed select RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef WALL_FOLLOW_SPEED_SELECT_DEFINES_SVH
`define WALL_FOLLOW_SPEED_SELECT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WFSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WFSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/wfss_pkg.sv -----
// Package for the wall follow speed select block: payload types, register codes,
// constants and the elaboration-time angle and gain table functions. No dependencies.
package wfss_pkg;

  localparam int SENSOR_SPACING  = 15;
  localparam int ANGLE_FRAC_BITS = 12;
  localparam int ANGLE_W         = ANGLE_FRAC_BITS + 1;
  localparam int GAIN_W          = 11;
  localparam int NUM_W           = 32;
  localparam int DIST_W          = 8;
  localparam int TBL_DEPTH       = 1 << DIST_W;
  localparam int CORDIC_STEPS    = 28;
  localparam int CORDIC_PRESHIFT = 20;

  localparam int GAIN_BASE   = 16;
  localparam int GAIN_STEP   = 5;
  localparam int ANGLE_SCALE = 10;
  localparam int BAND_NEAR   = 10;
  localparam int BAND_MID    = 60;
  localparam int BAND_FAR    = 800;

  localparam logic [DIST_W-1:0] WALL_MIN_RST = 8'd11;
  localparam logic [DIST_W-1:0] WALL_MAX_RST = 8'd40;
  localparam logic [DIST_W-1:0] STOP_MAX_RST = 8'd16;
  localparam logic [DIST_W-1:0] DIST_REF_RST = 8'd17;

  localparam logic [1:0] SPEED_STOP = 2'd0;
  localparam logic [1:0] SPEED_SLOW = 2'd1;
  localparam logic [1:0] SPEED_MID  = 2'd2;
  localparam logic [1:0] SPEED_FAST = 2'd3;

  localparam int FLAG_FRONT = 0;
  localparam int FLAG_BACK  = 1;
  localparam int FLAG_LEFT  = 2;
  localparam int FLAG_RIGHT = 3;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_WALL_MIN,
    REG_WALL_MAX,
    REG_STOP_MAX,
    REG_DIST_REF
  } reg_idx_t;

  typedef struct packed {
    logic [DIST_W-1:0] right_front_distance;
    logic [DIST_W-1:0] left_front_distance;
    logic [DIST_W-1:0] front_distance;
    logic [DIST_W-1:0] right_back_distance;
    logic [DIST_W-1:0] left_back_distance;
    logic [DIST_W-1:0] back_distance;
  } scan_t;

  typedef struct packed {
    logic [1:0] left_speed;
    logic [1:0] right_wheel_speed;
    logic       wall_stop;
    logic [3:0] wall_flags;
  } speed_t;

  localparam longint ATAN_Q30 [CORDIC_STEPS] = '{
    843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
    16775852, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8
  };

  function automatic logic in_range(input logic [DIST_W-1:0] v, input logic [DIST_W-1:0] lo,
                                    input logic [DIST_W-1:0] hi);
    return (lo <= v) && (v <= hi);
  endfunction

  // Arithmetic shift that truncates toward zero, matching integer division.
  function automatic longint shr_tz(input longint v, input int sh);
    return (v < 0) ? -((-v) >>> sh) : (v >>> sh);
  endfunction

  // Vectoring CORDIC for atan(mag / SENSOR_SPACING), evaluated at elaboration.
  function automatic logic [ANGLE_W-1:0] angle_fixed(input logic [DIST_W-1:0] mag);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint r;
    x = longint'(SENSOR_SPACING) <<< CORDIC_PRESHIFT;
    y = longint'(mag) <<< CORDIC_PRESHIFT;
    z = 0;
    if (mag == '0) begin
      return '0;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = shr_tz(x, i);
      ys = shr_tz(y, i);
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q30[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q30[i];
      end
    end
    if (z < 0) begin
      z = 0;
    end
    r = (z + (longint'(1) <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
    return r[ANGLE_W-1:0];
  endfunction

  function automatic logic [GAIN_W-1:0] gain_of(input logic [DIST_W-1:0] mag);
    int q;
    q = int'(mag) / SENSOR_SPACING;
    return GAIN_W'(GAIN_BASE + GAIN_STEP * q);
  endfunction

endpackage

// ----- sv/wall_follow_speed_select.sv -----
// Wall follow speed select: one input register, one combinational steering pass, one result
// register. Depends on wfss_pkg and wall_follow_speed_select_defines.svh.
//
// Usage: a transaction on the in_ channel carries one scan of six IR distance readings.
// Each scan yields exactly one transaction on the out_ channel with left and right speed
// codes, a stop flag and the wall presence flags. Thresholds and the side distance
// reference sit in four 8-bit registers behind the APB port at byte addresses 0, 4, 8
// and 12; writes complete in the access cycle and reads return the stored value.
// Registers should only be written while no scan is in flight.
// A scan is captured in the input register, then in the result register that drives
// out_valid. Throughput is one scan per cycle while out_ready stays high; each register
// holds one scan, and the angle and gain lookups plus one multiply sit between them.
// Reset (synchronous, active low) empties both stages and loads the register defaults.
// When the receiver holds out_ready low the result stays in place, the input stage
// fills, and in_ready drops only once both stages are full.
`include "wall_follow_speed_select_defines.svh"

module wall_follow_speed_select
  import wfss_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  scan_t              in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output speed_t             out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [DIST_W-1:0] wall_min_r;
  logic [DIST_W-1:0] wall_max_r;
  logic [DIST_W-1:0] stop_max_r;
  logic [DIST_W-1:0] dist_ref_r;

  scan_t  s1_r;
  logic   s1_v_r;
  speed_t out_r;
  logic   out_v_r;
  speed_t res_nxt;
  logic   s1_adv;
  logic   cfg_wr;
  reg_idx_t reg_idx;

  logic [ANGLE_W-1:0] ang_tbl  [TBL_DEPTH];
  logic [GAIN_W-1:0]  gain_tbl [TBL_DEPTH];

  for (genvar g = 0; g < TBL_DEPTH; g++) begin : g_tbl
    assign ang_tbl[g]  = angle_fixed(DIST_W'(g));
    assign gain_tbl[g] = gain_of(DIST_W'(g));
  end

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_WALL_MIN: prdata = PDATA_W'(wall_min_r);
      REG_WALL_MAX: prdata = PDATA_W'(wall_max_r);
      REG_STOP_MAX: prdata = PDATA_W'(stop_max_r);
      REG_DIST_REF: prdata = PDATA_W'(dist_ref_r);
      default:      prdata = '0;
    endcase
  end

  assign s1_adv    = !out_v_r || out_ready;
  assign in_ready  = !s1_v_r || s1_adv;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      wall_min_r <= WALL_MIN_RST;
      wall_max_r <= WALL_MAX_RST;
      stop_max_r <= STOP_MAX_RST;
      dist_ref_r <= DIST_REF_RST;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (s1_adv) begin
        out_v_r <= s1_v_r;
      end
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_WALL_MIN: wall_min_r <= pwdata[DIST_W-1:0];
          REG_WALL_MAX: wall_max_r <= pwdata[DIST_W-1:0];
          REG_STOP_MAX: stop_max_r <= pwdata[DIST_W-1:0];
          REG_DIST_REF: dist_ref_r <= pwdata[DIST_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (s1_adv && s1_v_r) begin
      out_r <= res_nxt;
    end
  end

  logic                     wf, wb, wl_raw, wr_raw, wl, wr, stop;
  logic [DIST_W:0]          sum_l, sum_r, sum_ab;
  logic [DIST_W-1:0]        a, b, mag, avg;
  logic signed [DIST_W:0]   d;
  logic [ANGLE_W-1:0]       ang_mag;
  logic signed [ANGLE_W:0]  ang_s;
  logic [GAIN_W-1:0]        gain;
  logic signed [DIST_W+1:0] align;
  logic signed [NUM_W-1:0]  prod, num, value;

  always_comb begin
    wf     = in_range(s1_r.front_distance, wall_min_r, wall_max_r);
    wb     = in_range(s1_r.back_distance, wall_min_r, wall_max_r);
    wl_raw = in_range(s1_r.left_front_distance, wall_min_r, wall_max_r) &&
             in_range(s1_r.left_back_distance, wall_min_r, wall_max_r);
    wr_raw = in_range(s1_r.right_front_distance, wall_min_r, wall_max_r) &&
             in_range(s1_r.right_back_distance, wall_min_r, wall_max_r);
    sum_l  = {1'b0, s1_r.left_front_distance} + {1'b0, s1_r.left_back_distance};
    sum_r  = {1'b0, s1_r.right_front_distance} + {1'b0, s1_r.right_back_distance};
    wl     = wl_raw && !(wr_raw && (sum_r < sum_l));
    wr     = wr_raw && !(wl_raw && !(sum_r < sum_l));
    stop   = (wall_min_r <= s1_r.front_distance) && (s1_r.front_distance <= stop_max_r);

    a       = wl ? s1_r.left_front_distance : s1_r.right_back_distance;
    b       = wl ? s1_r.left_back_distance : s1_r.right_front_distance;
    d       = $signed({1'b0, a}) - $signed({1'b0, b});
    mag     = d[DIST_W] ? DIST_W'(-d) : d[DIST_W-1:0];
    ang_mag = ang_tbl[mag];
    ang_s   = d[DIST_W] ? -$signed({1'b0, ang_mag}) : $signed({1'b0, ang_mag});
    gain    = gain_tbl[mag];
    sum_ab  = {1'b0, a} + {1'b0, b};
    avg     = sum_ab[DIST_W:1];
    align   = $signed({2'b00, dist_ref_r}) - $signed({2'b00, avg});
    if (wl) begin
      align = -align;
    end

    prod  = NUM_W'(ang_s) * $signed(NUM_W'(gain));
    num   = (prod <<< 3) + (prod <<< 1) + (NUM_W'(align) <<< ANGLE_FRAC_BITS);
    value = (num < 0) ? ((num + NUM_W'((1 << ANGLE_FRAC_BITS) - 1)) >>> ANGLE_FRAC_BITS)
                      : (num >>> ANGLE_FRAC_BITS);

    res_nxt                        = '0;
    res_nxt.wall_flags[FLAG_FRONT] = wf;
    res_nxt.wall_flags[FLAG_BACK]  = wb;
    res_nxt.wall_flags[FLAG_LEFT]  = wl;
    res_nxt.wall_flags[FLAG_RIGHT] = wr;
    if (stop) begin
      res_nxt.left_speed        = SPEED_STOP;
      res_nxt.right_wheel_speed = SPEED_STOP;
      res_nxt.wall_stop         = 1'b1;
    end else if (wl || wr) begin
      if (value > -BAND_NEAR && value < BAND_NEAR) begin
        res_nxt.left_speed        = SPEED_SLOW;
        res_nxt.right_wheel_speed = SPEED_SLOW;
      end else if (value >= BAND_NEAR && value < BAND_MID) begin
        res_nxt.left_speed        = SPEED_MID;
        res_nxt.right_wheel_speed = SPEED_SLOW;
      end else if (value >= BAND_MID && value < BAND_FAR) begin
        res_nxt.left_speed        = SPEED_FAST;
        res_nxt.right_wheel_speed = SPEED_SLOW;
      end else if (value <= -BAND_NEAR && value > -BAND_MID) begin
        res_nxt.left_speed        = SPEED_SLOW;
        res_nxt.right_wheel_speed = SPEED_MID;
      end else if (value <= -BAND_MID && value > -BAND_FAR) begin
        res_nxt.left_speed        = SPEED_SLOW;
        res_nxt.right_wheel_speed = SPEED_FAST;
      end else begin
        res_nxt.left_speed        = SPEED_STOP;
        res_nxt.right_wheel_speed = SPEED_STOP;
      end
    end else begin
      res_nxt.left_speed        = SPEED_SLOW;
      res_nxt.right_wheel_speed = SPEED_SLOW;
    end
  end

  `WFSS_ASSERT_NOW(a_stop_speeds, out_v_r && out_r.wall_stop,
    (out_r.left_speed == SPEED_STOP) && (out_r.right_wheel_speed == SPEED_STOP),
    "stop result with nonzero speed")
  `WFSS_ASSERT_NOW(a_one_side, out_v_r,
    !(out_r.wall_flags[FLAG_LEFT] && out_r.wall_flags[FLAG_RIGHT]),
    "both side walls reported")
  `WFSS_ASSERT_NOW(a_no_side_cruise,
    out_v_r && !out_r.wall_stop && !out_r.wall_flags[FLAG_LEFT] &&
    !out_r.wall_flags[FLAG_RIGHT],
    (out_r.left_speed == SPEED_SLOW) && (out_r.right_wheel_speed == SPEED_SLOW),
    "no side wall but speeds are not cruise")
  `WFSS_ASSERT_NEXT(a_stage_hold, s1_v_r && out_v_r && !out_ready,
    s1_v_r && out_v_r, "stalled transaction dropped from the pipeline")

endmodule

// ----- bench/tb_wall_follow_speed_select.sv -----
// Self-checking testbench for wall_follow_speed_select: scans go in through a queued
// valid/ready driver, results are predicted per transaction and checked by a monitor.
// Depends on wfss_pkg for the payload types, register codes and speed codes.
module tb_wall_follow_speed_select;
  import wfss_pkg::*;

  localparam int     SENSOR_GAP    = 15;
  localparam int     FRAC_W        = 12;
  localparam int     STEPS         = 28;
  localparam longint STEER_BASE    = 16;
  localparam longint STEER_STEP    = 5;
  localparam longint STEER_SCALE   = 10;
  localparam longint BAND_NEAR_LIM = 10;
  localparam longint BAND_MID_LIM  = 60;
  localparam longint BAND_FAR_LIM  = 800;
  localparam int     PHASES        = 8;
  localparam int     PHASE_SCANS   = 250;
  localparam int     CYCLE_LIMIT   = 400000;

  localparam longint ARCTAN_Q30 [STEPS] = '{
    843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
    16775852, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  scan_t              in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  speed_t             out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic [7:0] lim_lo = 8'd11;
  logic [7:0] lim_hi = 8'd40;
  logic [7:0] stop_hi = 8'd16;
  logic [7:0] side_ref = 8'd17;

  scan_t  scan_q[$];
  speed_t speed_q[$];
  bit     in_took = 1'b0;
  int     send_gap = 0;
  int     recv_stall = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     cycle_cnt = 0;
  int     scans_taken = 0;
  int     results_seen = 0;
  int     stops_seen = 0;
  int     left_code_seen [4] = '{0, 0, 0, 0};
  int     settings_used = 1;
  int     mismatches = 0;

  wall_follow_speed_select u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_wall(input logic [7:0] v);
    return (lim_lo <= v) && (v <= lim_hi);
  endfunction

  // Vectoring rotation toward the x axis; the accumulated angle is rounded to FRAC_W bits.
  function automatic longint atan_q12(input longint mag);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint div;
    x = longint'(SENSOR_GAP) <<< 20;
    y = mag <<< 20;
    z = 0;
    if (mag == 0) begin
      return 0;
    end
    for (int i = 0; i < STEPS; i++) begin
      div = longint'(1) <<< i;
      xs = x / div;
      ys = y / div;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_Q30[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_Q30[i];
      end
    end
    if (z < 0) begin
      z = 0;
    end
    return (z + (longint'(1) <<< (29 - FRAC_W))) >>> (30 - FRAC_W);
  endfunction

  function automatic speed_t steer_speeds(input scan_t s);
    speed_t r;
    bit     fw;
    bit     bw;
    bit     lw;
    bit     rw;
    longint a;
    longint b;
    longint d;
    longint mag;
    longint ang;
    longint gain;
    longint align;
    longint val;
    fw = is_wall(s.front_distance);
    bw = is_wall(s.back_distance);
    lw = is_wall(s.left_front_distance) && is_wall(s.left_back_distance);
    rw = is_wall(s.right_front_distance) && is_wall(s.right_back_distance);
    if (lw && rw) begin
      if (int'(s.right_front_distance) + int'(s.right_back_distance) <
          int'(s.left_front_distance) + int'(s.left_back_distance)) begin
        lw = 1'b0;
      end else begin
        rw = 1'b0;
      end
    end
    r = '0;
    if (lim_lo <= s.front_distance && s.front_distance <= stop_hi) begin
      r.left_speed        = SPEED_STOP;
      r.right_wheel_speed = SPEED_STOP;
      r.wall_stop         = 1'b1;
    end else if (lw || rw) begin
      a = lw ? longint'(s.left_front_distance) : longint'(s.right_back_distance);
      b = lw ? longint'(s.left_back_distance) : longint'(s.right_front_distance);
      d = a - b;
      mag = (d < 0) ? -d : d;
      ang = atan_q12(mag);
      gain = STEER_BASE + STEER_STEP * (mag / SENSOR_GAP);
      align = longint'(side_ref) - (a + b) / 2;
      if (d < 0) begin
        ang = -ang;
      end
      if (lw) begin
        align = -align;
      end
      val = (STEER_SCALE * ang * gain + align * (longint'(1) <<< FRAC_W)) /
            (longint'(1) <<< FRAC_W);
      if (val > -BAND_NEAR_LIM && val < BAND_NEAR_LIM) begin
        r.left_speed        = SPEED_SLOW;
        r.right_wheel_speed = SPEED_SLOW;
      end else if (val >= BAND_NEAR_LIM && val < BAND_MID_LIM) begin
        r.left_speed        = SPEED_MID;
        r.right_wheel_speed = SPEED_SLOW;
      end else if (val >= BAND_MID_LIM && val < BAND_FAR_LIM) begin
        r.left_speed        = SPEED_FAST;
        r.right_wheel_speed = SPEED_SLOW;
      end else if (val <= -BAND_NEAR_LIM && val > -BAND_MID_LIM) begin
        r.left_speed        = SPEED_SLOW;
        r.right_wheel_speed = SPEED_MID;
      end else if (val <= -BAND_MID_LIM && val > -BAND_FAR_LIM) begin
        r.left_speed        = SPEED_SLOW;
        r.right_wheel_speed = SPEED_FAST;
      end else begin
        r.left_speed        = SPEED_STOP;
        r.right_wheel_speed = SPEED_STOP;
      end
    end else begin
      r.left_speed        = SPEED_SLOW;
      r.right_wheel_speed = SPEED_SLOW;
    end
    r.wall_flags[FLAG_FRONT] = fw;
    r.wall_flags[FLAG_BACK]  = bw;
    r.wall_flags[FLAG_LEFT]  = lw;
    r.wall_flags[FLAG_RIGHT] = rw;
    return r;
  endfunction

  function automatic scan_t mk_scan(input logic [7:0] rf, input logic [7:0] lf,
                                    input logic [7:0] fr, input logic [7:0] rb,
                                    input logic [7:0] lb, input logic [7:0] bk);
    scan_t s;
    s.right_front_distance = rf;
    s.left_front_distance  = lf;
    s.front_distance       = fr;
    s.right_back_distance  = rb;
    s.left_back_distance   = lb;
    s.back_distance        = bk;
    return s;
  endfunction

  // Mostly readings inside the wall range so that the steering path is reached.
  function automatic logic [7:0] pick_reading();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 && lim_lo <= lim_hi) begin
      return 8'($urandom_range(lim_hi, lim_lo));
    end else if (r == 6) begin
      case ($urandom_range(0, 3))
        0: return lim_lo;
        1: return lim_lo - 8'd1;
        2: return lim_hi;
        default: return lim_hi + 8'd1;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic scan_t pick_scan();
    scan_t s;
    s = mk_scan(pick_reading(), pick_reading(), pick_reading(), pick_reading(),
                pick_reading(), pick_reading());
    if ($urandom_range(0, 4) == 0 && lim_lo <= stop_hi) begin
      s.front_distance = 8'($urandom_range(stop_hi, lim_lo));
    end
    if ($urandom_range(0, 9) == 0) begin
      s.right_front_distance = s.left_back_distance;
      s.right_back_distance  = s.left_front_distance;
    end
    return s;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= PDATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WALL_MIN: lim_lo = val;
      REG_WALL_MAX: lim_hi = val;
      REG_STOP_MAX: stop_hi = val;
      REG_DIST_REF: side_ref = val;
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [7:0] lo, input logic [7:0] hi,
                              input logic [7:0] stop, input logic [7:0] ref_dist);
    write_reg(REG_WALL_MIN, lo);
    write_reg(REG_WALL_MAX, hi);
    write_reg(REG_STOP_MAX, stop);
    write_reg(REG_DIST_REF, ref_dist);
    settings_used++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (scan_q.size() != 0 || in_valid || speed_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (rst_n && scan_q.size() != 0) begin
        in_data  <= scan_q.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(1, 18);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (recv_stall > 0) begin
      recv_stall--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < recv_stall_pct) begin
      recv_stall = $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    speed_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("wall_follow_speed_select: mismatch");
      $finish;
    end else begin
      in_took = rst_n && in_valid && in_ready;
      if (in_took) begin
        speed_q.push_back(steer_speeds(in_data));
        scans_taken++;
      end
      if (rst_n && out_valid && out_ready) begin
        results_seen++;
        if (speed_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result transaction %p at cycle %0d", out_data, cycle_cnt);
          end
          mismatches++;
        end else begin
          want = speed_q.pop_front();
          if (out_data.left_speed !== want.left_speed ||
              out_data.right_wheel_speed !== want.right_wheel_speed ||
              out_data.wall_stop !== want.wall_stop ||
              out_data.wall_flags !== want.wall_flags) begin
            if (mismatches < 10) begin
              $display("result %0d: expected %p, got %p", results_seen, want, out_data);
            end
            mismatches++;
          end
          if (want.wall_stop) begin
            stops_seen++;
          end
          left_code_seen[want.left_speed]++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct  = 10;
    recv_stall_pct = 10;

    scan_q.push_back(mk_scan(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    scan_q.push_back(mk_scan(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    scan_q.push_back(mk_scan(8'd20, 8'd20, 8'd12, 8'd20, 8'd20, 8'd20));
    scan_q.push_back(mk_scan(8'd20, 8'd25, 8'd16, 8'd30, 8'd20, 8'd30));
    scan_q.push_back(mk_scan(8'd20, 8'd25, 8'd17, 8'd30, 8'd20, 8'd30));
    scan_q.push_back(mk_scan(8'd50, 8'd50, 8'd50, 8'd50, 8'd50, 8'd50));
    scan_q.push_back(mk_scan(8'd0, 8'd40, 8'd100, 8'd0, 8'd11, 8'd0));
    scan_q.push_back(mk_scan(8'd0, 8'd11, 8'd100, 8'd0, 8'd40, 8'd0));
    scan_q.push_back(mk_scan(8'd0, 8'd20, 8'd100, 8'd0, 8'd20, 8'd11));
    scan_q.push_back(mk_scan(8'd11, 8'd0, 8'd41, 8'd40, 8'd0, 8'd40));
    scan_q.push_back(mk_scan(8'd40, 8'd0, 8'd10, 8'd11, 8'd0, 8'd41));
    scan_q.push_back(mk_scan(8'd20, 8'd25, 8'd100, 8'd30, 8'd25, 8'd0));
    scan_q.push_back(mk_scan(8'd12, 8'd30, 8'd100, 8'd12, 8'd30, 8'd0));
    scan_q.push_back(mk_scan(8'd0, 8'd35, 8'd100, 8'd0, 8'd20, 8'd0));
    scan_q.push_back(mk_scan(8'd0, 8'd34, 8'd100, 8'd0, 8'd20, 8'd0));
    scan_q.push_back(mk_scan(8'd10, 8'd41, 8'd11, 8'd41, 8'd10, 8'd0));
    scan_q.push_back(mk_scan(8'd33, 8'd17, 8'd200, 8'd17, 8'd17, 8'd40));
    scan_q.push_back(mk_scan(8'd11, 8'd40, 8'd100, 8'd40, 8'd11, 8'd100));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: ;
        1: load_setting(8'd0, 8'd255, 8'd0, 8'd0);
        2: load_setting(8'd255, 8'd0, 8'd255, 8'd255);
        3: load_setting(8'd20, 8'd60, 8'd10, 8'd40);
        4: load_setting(8'd0, 8'd255, 8'd255, 8'd128);
        PHASES - 1: load_setting(8'd11, 8'd40, 8'd16, 8'd17);
        default: load_setting(8'($urandom_range(0, 60)), 8'($urandom_range(30, 255)),
                              8'($urandom_range(0, 80)), 8'($urandom_range(0, 255)));
      endcase
      send_idle_pct  = (p == 3 || p == PHASES - 1) ? 0 : ((p % 2 == 0) ? 8 : 25);
      recv_stall_pct = (p == 5 || p == PHASES - 1) ? 0 : ((p % 2 == 0) ? 25 : 8);
      for (int k = 0; k < PHASE_SCANS; k++) begin
        scan_q.push_back(pick_scan());
      end
      wait_drained();
    end

    repeat (5) @(negedge clk);
    $display("%0d scans and %0d results over %0d register settings; %0d stops,",
             scans_taken, results_seen, settings_used, stops_seen);
    $display("left speed codes 0..3 seen %0d/%0d/%0d/%0d times, %0d mismatches",
             left_code_seen[0], left_code_seen[1], left_code_seen[2], left_code_seen[3],
             mismatches);
    if (mismatches == 0 && speed_q.size() == 0) begin
      $display("wall_follow_speed_select: match");
    end else begin
      $display("%0d expected results never arrived", speed_q.size());
      $display("wall_follow_speed_select: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/wfss_pkg.sv
sv/wall_follow_speed_select.sv
bench/tb_wall_follow_speed_select.sv
